[rtl/core/fqr_pkg.sv]
// shared types and constants for the queue with remove by identifier
package fqr_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_KILL  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic capture;
    logic kill_apply;
  } fqr_ctrl_t;

endpackage

[rtl/core/fqr_if.sv]
// valid/ready channel interfaces for commands and results
interface fqr_in_if #(
  parameter int ID_WIDTH = fqr_pkg::ID_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [ID_WIDTH-1:0] pid;

  modport source (output valid, output op, output pid, input ready);
  modport sink   (input valid, input op, input pid, output ready);
endinterface

interface fqr_out_if #(
  parameter int ID_WIDTH  = fqr_pkg::ID_WIDTH_DEF,
  parameter int CNT_WIDTH = $clog2(fqr_pkg::DEPTH_DEF + 1)
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 out_valid;
  logic [ID_WIDTH-1:0]  out_pid;
  logic [CNT_WIDTH-1:0] count;
  logic [ID_WIDTH-1:0]  front_pid;
  logic [ID_WIDTH-1:0]  rear_pid;
  logic                 is_empty;

  modport source (output valid, output status, output out_valid, output out_pid,
                  output count, output front_pid, output rear_pid, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input out_valid, input out_pid,
                  input count, input front_pid, input rear_pid, input is_empty,
                  output ready);
endinterface

[rtl/core/fqr_cell.sv]
// one queue cell: holds an identifier, compares it and shifts from its neighbour
module fqr_cell #(
  parameter int ID_WIDTH = fqr_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  fqr_pkg::fqr_ctrl_t  ctrl,
  input  logic                sel_push,
  input  logic                live,
  input  logic [ID_WIDTH-1:0] pid,
  input  logic [ID_WIDTH-1:0] nbr_val,
  input  logic                found_in,
  output logic                found_out,
  output logic [ID_WIDTH-1:0] val
);

  logic [ID_WIDTH-1:0] val_r;
  logic                match_r;

  // set once this cell or any cell nearer the front matched
  assign found_out = found_in | match_r;
  assign val       = val_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match_r <= live && (val_r == pid);
    end
    if (ctrl.push && sel_push) begin
      val_r <= pid;
    end else if (ctrl.pop || (ctrl.kill_apply && found_out)) begin
      val_r <= nbr_val;
    end
  end

endmodule

[rtl/core/fifo_queue_with_remove_by_id_top.sv]
// ordered identifier queue with push, pop, remove by identifier and clear
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          op, pid
//   out_ch   out  valid/ready          status, out_valid, out_pid, count,
//                                      front_pid, rear_pid, is_empty
//
// the result is loaded into the output register from the report state; push, pop
// and clear pass through exec and report, remove by identifier through exec,
// shift and report: exec registers the per-cell compare, shift lets the match
// ripple down the cell row and compact, report forms front and rear. in_ready
// rises as the result is loaded; a stalled output holds the item in report.
// one item is in work at a time; a waiting result does not block the next
// accept, but that item's result holds until the output register is free.
// reset empties the queue at once; cell contents are not cleared.
module fifo_queue_with_remove_by_id_top #(
  parameter int DEPTH    = fqr_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = fqr_pkg::ID_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  fqr_in_if.sink   in_ch,
  fqr_out_if.source out_ch
);

  localparam int CNT_WIDTH = $clog2(DEPTH + 1);
  localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_REPORT
  } state_t;

  state_t               state_r;
  fqr_pkg::op_t         op_r;
  logic [ID_WIDTH-1:0]  pid_r;
  logic [CNT_WIDTH-1:0] held_r;
  fqr_pkg::status_t     st_r;
  logic                 ov_r;
  logic [ID_WIDTH-1:0]  opid_r;

  logic                 o_valid_r;
  fqr_pkg::status_t     o_status_r;
  logic                 o_ov_r;
  logic [ID_WIDTH-1:0]  o_pid_r;
  logic [CNT_WIDTH-1:0] o_count_r;
  logic [ID_WIDTH-1:0]  o_front_r;
  logic [ID_WIDTH-1:0]  o_rear_r;
  logic                 o_empty_r;

  fqr_pkg::fqr_ctrl_t   ctrl;
  logic [DEPTH-1:0]     sel_push;
  logic [DEPTH-1:0]     live;
  logic [DEPTH:0]       found;
  logic [ID_WIDTH-1:0]  cell_val [DEPTH];
  logic [ID_WIDTH-1:0]  rear_val;
  logic                 out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !o_valid_r || out_ch.ready;

  always_comb begin
    ctrl            = '0;
    ctrl.push       = (state_r == S_EXEC) && (op_r == fqr_pkg::OP_PUSH) &&
                      (held_r != FULL_CNT);
    ctrl.pop        = (state_r == S_EXEC) && (op_r == fqr_pkg::OP_POP) &&
                      (held_r != '0);
    ctrl.capture    = (state_r == S_EXEC) && (op_r == fqr_pkg::OP_KILL);
    ctrl.kill_apply = (state_r == S_SHIFT);
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] nbr;
    assign sel_push[i] = (held_r == CNT_WIDTH'(i));
    assign live[i]     = (CNT_WIDTH'(i) < held_r);
    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    fqr_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel_push  (sel_push[i]),
      .live      (live[i]),
      .pid       (pid_r),
      .nbr_val   (nbr),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .val       (cell_val[i])
    );
  end

  // rear entry sits at held - 1
  always_comb begin
    rear_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (held_r == CNT_WIDTH'(i + 1)) begin
        rear_val = rear_val | cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      o_valid_r <= 1'b0;
    end else begin
      // load a new result or keep the one still waiting
      o_valid_r <= ((state_r == S_REPORT) && out_free) || (o_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= fqr_pkg::op_t'(in_ch.op);
            pid_r   <= in_ch.pid;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r    <= fqr_pkg::ST_OK;
          ov_r    <= 1'b0;
          opid_r  <= '0;
          state_r <= S_REPORT;
          unique case (op_r)
            fqr_pkg::OP_PUSH: begin
              if (held_r == FULL_CNT) begin
                st_r <= fqr_pkg::ST_FULL;
              end else begin
                held_r <= held_r + CNT_WIDTH'(1);
              end
            end
            fqr_pkg::OP_POP: begin
              if (held_r == '0) begin
                st_r <= fqr_pkg::ST_EMPTY;
              end else begin
                ov_r   <= 1'b1;
                opid_r <= cell_val[0];
                held_r <= held_r - CNT_WIDTH'(1);
              end
            end
            fqr_pkg::OP_KILL: begin
              if (held_r == '0) begin
                st_r <= fqr_pkg::ST_EMPTY;
              end else begin
                state_r <= S_SHIFT;
              end
            end
            fqr_pkg::OP_CLEAR: begin
              held_r <= '0;
            end
            default: begin
              state_r <= S_REPORT;
            end
          endcase
        end
        S_SHIFT: begin
          state_r <= S_REPORT;
          if (found[DEPTH]) begin
            st_r   <= fqr_pkg::ST_OK;
            ov_r   <= 1'b1;
            opid_r <= pid_r;
            held_r <= held_r - CNT_WIDTH'(1);
          end else begin
            st_r <= fqr_pkg::ST_NOTFOUND;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            o_status_r <= st_r;
            o_ov_r     <= ov_r;
            o_pid_r    <= opid_r;
            o_count_r  <= held_r;
            o_front_r  <= (held_r != '0) ? cell_val[0] : '0;
            o_rear_r   <= rear_val;
            o_empty_r  <= (held_r == '0);
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = o_valid_r;
  assign out_ch.status    = o_status_r;
  assign out_ch.out_valid = o_ov_r;
  assign out_ch.out_pid   = o_pid_r;
  assign out_ch.count     = o_count_r;
  assign out_ch.front_pid = o_front_r;
  assign out_ch.rear_pid  = o_rear_r;
  assign out_ch.is_empty  = o_empty_r;

endmodule

[rtl/core/fqr_checker.sv]
// port-level checks on the queue results, bound to the top level
module fqr_checker #(
  parameter int DEPTH     = fqr_pkg::DEPTH_DEF,
  parameter int ID_WIDTH  = fqr_pkg::ID_WIDTH_DEF,
  parameter int CNT_WIDTH = $clog2(fqr_pkg::DEPTH_DEF + 1)
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 o_valid,
  input logic                 o_ready,
  input logic [1:0]           o_status,
  input logic                 o_out_valid,
  input logic [CNT_WIDTH-1:0] o_count,
  input logic [ID_WIDTH-1:0]  o_front,
  input logic [ID_WIDTH-1:0]  o_rear,
  input logic                 o_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_empty == (o_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_empty |-> (o_front == '0) && (o_rear == '0))
    else $error("front or rear set on an empty queue");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_out_valid |-> (o_status == fqr_pkg::ST_OK) && (o_count < CNT_WIDTH'(DEPTH)))
    else $error("removed item with bad status or count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_count <= CNT_WIDTH'(DEPTH)))
    else $error("count beyond depth");

endmodule

bind fifo_queue_with_remove_by_id_top fqr_checker #(
  .DEPTH     (DEPTH),
  .ID_WIDTH  (ID_WIDTH),
  .CNT_WIDTH (CNT_WIDTH)
) u_fqr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .o_valid     (out_ch.valid),
  .o_ready     (out_ch.ready),
  .o_status    (out_ch.status),
  .o_out_valid (out_ch.out_valid),
  .o_count     (out_ch.count),
  .o_front     (out_ch.front_pid),
  .o_rear      (out_ch.rear_pid),
  .o_empty     (out_ch.is_empty)
);

[tb/sv/testbench.sv]
// testbench for the identifier queue: directed table, then random commands checked against a mirror
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = fqr_pkg::DEPTH_DEF;
  localparam int ID_W        = fqr_pkg::ID_WIDTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 462;

  // command mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  typedef struct packed {
    fqr_pkg::status_t    status;
    logic                out_valid;
    logic [ID_W-1:0]     out_pid;
    logic [CNT_W-1:0]    count;
    logic [ID_W-1:0]     front_pid;
    logic [ID_W-1:0]     rear_pid;
    logic                is_empty;
  } queue_report_t;

  typedef struct packed {
    fqr_pkg::op_t    op;
    logic [ID_W-1:0] pid;
    logic            typed;
    queue_report_t   want;
  } cmd_row_t;

  logic clk;
  logic rst_n;

  fqr_in_if  #(.ID_WIDTH(ID_W)) in_ch ();
  fqr_out_if #(.ID_WIDTH(ID_W), .CNT_WIDTH(CNT_W)) out_ch ();

  fifo_queue_with_remove_by_id_top #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [ID_W-1:0] shadow_ids[$];
  queue_report_t   due_reports[$];
  cmd_row_t        cmd_table[$];

  int   mismatches;
  int   reports_checked;
  int   op_seen[4];
  int   full_hits;
  int   miss_hits;
  int   empty_hits;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   hold_reqs;
  int   holds_done;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("mismatch at %0t on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic queue_report_t report_of(input fqr_pkg::status_t st, input logic v,
                                              input logic [ID_W-1:0] p,
                                              input logic [CNT_W-1:0] n,
                                              input logic [ID_W-1:0] f,
                                              input logic [ID_W-1:0] r,
                                              input logic e);
    queue_report_t rep;
    rep.status    = st;
    rep.out_valid = v;
    rep.out_pid   = p;
    rep.count     = n;
    rep.front_pid = f;
    rep.rear_pid  = r;
    rep.is_empty  = e;
    return rep;
  endfunction

  // mirror of the queue: applies one command and returns the report it gives
  function automatic queue_report_t apply_queue_cmd(input fqr_pkg::op_t op,
                                                    input logic [ID_W-1:0] pid);
    queue_report_t rep;
    logic          found;
    int            i;
    rep   = '0;
    found = 1'b0;
    rep.status = fqr_pkg::ST_OK;
    case (op)
      fqr_pkg::OP_PUSH: begin
        if (shadow_ids.size() >= DEPTH) rep.status = fqr_pkg::ST_FULL;
        else shadow_ids.push_back(pid);
      end
      fqr_pkg::OP_POP: begin
        if (shadow_ids.size() == 0) begin
          rep.status = fqr_pkg::ST_EMPTY;
        end else begin
          rep.out_valid = 1'b1;
          rep.out_pid   = shadow_ids.pop_front();
        end
      end
      fqr_pkg::OP_KILL: begin
        if (shadow_ids.size() == 0) begin
          rep.status = fqr_pkg::ST_EMPTY;
        end else begin
          rep.status = fqr_pkg::ST_NOTFOUND;
          // first match from the front goes, the rest close up in order
          for (i = 0; i < shadow_ids.size() && !found; i++) begin
            if (shadow_ids[i] == pid) begin
              found         = 1'b1;
              rep.status    = fqr_pkg::ST_OK;
              rep.out_valid = 1'b1;
              rep.out_pid   = pid;
              shadow_ids.delete(i);
            end
          end
        end
      end
      default: shadow_ids.delete();
    endcase
    rep.count     = CNT_W'(shadow_ids.size());
    rep.is_empty  = (shadow_ids.size() == 0);
    rep.front_pid = rep.is_empty ? '0 : shadow_ids[0];
    rep.rear_pid  = rep.is_empty ? '0 : shadow_ids[shadow_ids.size() - 1];
    return rep;
  endfunction

  task automatic send_cmd(input fqr_pkg::op_t op, input logic [ID_W-1:0] pid,
                          input logic typed, input queue_report_t want);
    queue_report_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.pid   <= pid;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = apply_queue_cmd(op, pid);
    op_seen[op]++;
    if (predicted.status == fqr_pkg::ST_FULL) full_hits++;
    if (predicted.status == fqr_pkg::ST_NOTFOUND) miss_hits++;
    if (predicted.status == fqr_pkg::ST_EMPTY) empty_hits++;
    due_reports.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input fqr_pkg::op_t op, input logic [ID_W-1:0] pid,
                         input logic typed, input queue_report_t want);
    cmd_row_t row;
    row.op    = op;
    row.pid   = pid;
    row.typed = typed;
    row.want  = want;
    cmd_table.push_back(row);
  endtask

  task automatic send_random_cmd(input int mix);
    int              r;
    int              sel;
    int              push_lim;
    int              pop_lim;
    fqr_pkg::op_t    op;
    logic [ID_W-1:0] pid;
    case (mix)
      MIX_FILL:  begin push_lim = 65; pop_lim = 77; end
      MIX_DRAIN: begin push_lim = 20; pop_lim = 60; end
      default:   begin push_lim = 40; pop_lim = 67; end
    endcase
    r = $urandom_range(99);
    if (r < push_lim)     op = fqr_pkg::OP_PUSH;
    else if (r < pop_lim) op = fqr_pkg::OP_POP;
    else if (r < 97)      op = fqr_pkg::OP_KILL;
    else                  op = fqr_pkg::OP_CLEAR;
    sel = $urandom_range(9);
    // kills mostly aim at a held identifier, pushes sometimes repeat one
    if (shadow_ids.size() != 0 && sel < ((op == fqr_pkg::OP_KILL) ? 7 : 2)) begin
      pid = shadow_ids[$urandom_range(shadow_ids.size() - 1)];
    end else if (sel < 4 || (op == fqr_pkg::OP_KILL && sel < 8)) begin
      case ($urandom_range(3))
        0:       pid = '0;
        1:       pid = '1;
        2:       pid = 16'h5555;
        default: pid = 16'hAAAA;
      endcase
    end else begin
      pid = ID_W'($urandom());
    end
    send_cmd(op, pid, 1'b0, '0);
  endtask

  task automatic check_report(input queue_report_t got, input queue_report_t want);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.out_valid !== want.out_valid)
      report_mismatch("out_valid", 32'(got.out_valid), 32'(want.out_valid));
    if (got.out_pid !== want.out_pid)
      report_mismatch("out_pid", 32'(got.out_pid), 32'(want.out_pid));
    if (got.count !== want.count)
      report_mismatch("count", 32'(got.count), 32'(want.count));
    if (got.front_pid !== want.front_pid)
      report_mismatch("front_pid", 32'(got.front_pid), 32'(want.front_pid));
    if (got.rear_pid !== want.rear_pid)
      report_mismatch("rear_pid", 32'(got.rear_pid), 32'(want.rear_pid));
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
  endtask

  always @(posedge clk) begin : result_monitor
    queue_report_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status    = fqr_pkg::status_t'(out_ch.status);
      got.out_valid = out_ch.out_valid;
      got.out_pid   = out_ch.out_pid;
      got.count     = out_ch.count;
      got.front_pid = out_ch.front_pid;
      got.rear_pid  = out_ch.rear_pid;
      got.is_empty  = out_ch.is_empty;
      if (due_reports.size() == 0) report_mismatch("result with nothing due", '0, '0);
      else check_report(got, due_reports.pop_front());
      reports_checked++;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs > holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("no handshake for %0d cycles, %0d results still due", STALL_LIMIT,
             due_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int k;
    int ph;
    mismatches      = 0;
    reports_checked = 0;
    full_hits       = 0;
    miss_hits       = 0;
    empty_hits      = 0;
    foreach (op_seen[j]) op_seen[j] = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_reqs       = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = fqr_pkg::OP_PUSH;
    in_ch.pid       = '0;
    out_ch.ready    = 1'b0;

    // directed table
    add_row(fqr_pkg::OP_POP,   '0, 1'b1,
            report_of(fqr_pkg::ST_EMPTY, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(fqr_pkg::OP_KILL,  '1, 1'b1,
            report_of(fqr_pkg::ST_EMPTY, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(fqr_pkg::OP_CLEAR, '0, 1'b1,
            report_of(fqr_pkg::ST_OK, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(fqr_pkg::OP_PUSH,  '0, 1'b1,
            report_of(fqr_pkg::ST_OK, 1'b0, '0, CNT_W'(1), '0, '0, 1'b0));
    // single entry held and no match
    add_row(fqr_pkg::OP_KILL,  '1, 1'b1,
            report_of(fqr_pkg::ST_NOTFOUND, 1'b0, '0, CNT_W'(1), '0, '0, 1'b0));
    add_row(fqr_pkg::OP_KILL,  '0, 1'b1,
            report_of(fqr_pkg::ST_OK, 1'b1, '0, '0, '0, '0, 1'b1));
    add_row(fqr_pkg::OP_PUSH,  '1, 1'b1,
            report_of(fqr_pkg::ST_OK, 1'b0, '0, CNT_W'(1), '1, '1, 1'b0));
    for (k = 1; k < DEPTH; k++) add_row(fqr_pkg::OP_PUSH, ID_W'(k * 16'h1111), 1'b0, '0);
    // full: item dropped, queue untouched
    add_row(fqr_pkg::OP_PUSH, 16'hA5A5, 1'b1,
            report_of(fqr_pkg::ST_FULL, 1'b0, '0, CNT_W'(DEPTH), '1, '1, 1'b0));
    add_row(fqr_pkg::OP_KILL, '1, 1'b0, '0);
    add_row(fqr_pkg::OP_KILL, 16'h7777, 1'b0, '0);
    add_row(fqr_pkg::OP_POP,  '0, 1'b0, '0);
    add_row(fqr_pkg::OP_CLEAR, '0, 1'b1,
            report_of(fqr_pkg::ST_OK, 1'b0, '0, '0, '0, '0, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (cmd_table[i])
      send_cmd(cmd_table[i].op, cmd_table[i].pid, cmd_table[i].typed, cmd_table[i].want);
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 55; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 55; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // long hold-off on results while items keep coming
        if (ph == 0 && k == 120) hold_reqs++;
        send_random_cmd((k / 40) % 3);
      end
      // sender waits for every result before the next phase
      in_ch.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clk);
    end

    repeat (12) @(posedge clk);
    $display("commands: %0d push, %0d pop, %0d remove, %0d clear; %0d results checked",
             op_seen[fqr_pkg::OP_PUSH], op_seen[fqr_pkg::OP_POP],
             op_seen[fqr_pkg::OP_KILL], op_seen[fqr_pkg::OP_CLEAR], reports_checked);
    $display("push on full %0d, remove with no match %0d, pop or remove on empty %0d",
             full_hits, miss_hits, empty_hits);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[fifo_queue_with_remove_by_id_top.f]
rtl/core/fqr_pkg.sv
rtl/core/fqr_if.sv
rtl/core/fqr_cell.sv
rtl/core/fifo_queue_with_remove_by_id_top.sv
rtl/core/fqr_checker.sv
tb/sv/testbench.sv
